/* hdl/itpaf_pkg.sv */
package itpaf_pkg;

    localparam int VALUE_W         = 64;
    localparam int MAX_WIDTH_DEF   = 64;
    localparam int DIGIT_SLOTS_DEF = 20;

    localparam logic [1:0] RADIX_DEC       = 2'd0;
    localparam logic [1:0] RADIX_HEX_UPPER = 2'd1;
    localparam logic [1:0] RADIX_HEX_LOWER = 2'd2;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;

    function automatic logic [7:0] digit_char(input logic [3:0] dig, input logic upper);
        logic [7:0] base;
        begin
            base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
            if (dig < 4'd10)
            begin
                digit_char = CHAR_ZERO + {4'd0, dig};
            end
            else
            begin
                digit_char = base + {4'd0, dig} - 8'd10;
            end
        end
    endfunction

endpackage

/* hdl/int_to_padded_ascii_formatter.sv */
// Sequence: in decimal mode a double-dabble conversion (two magnitude bits per cycle on one
// shared BCD adjust/shift unit), then a leading-zero scan; hex mode skips the conversion.
// Then one character per cycle, max(width, text length) of them.
// Throughput: one value at a time; busy drops in the same cycle that the last character is on out_char.
// The receiver cannot stall: each character is on out_char for one cycle with valid high.
// Reset (rst_n low, asynchronous) returns the sequencer to idle and drops valid.
module int_to_padded_ascii_formatter
    import itpaf_pkg::*;
#(
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
    parameter int DIGIT_SLOTS = DIGIT_SLOTS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [VALUE_W-1:0] value,
    input  logic [1:0]                radix_mode,
    input  logic                      zero_pad,
    input  logic [6:0]                field_width,
    output logic                      valid,
    output logic [7:0]                out_char,
    output logic                      last_char
);

    localparam int BCD_W   = DIGIT_SLOTS * 4;
    localparam int IDX_W   = $clog2(DIGIT_SLOTS);
    localparam int STEPS   = VALUE_W / 2;
    localparam int STEP_W  = $clog2(STEPS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [VALUE_W-1:0] mag_reg, mag_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               neg_reg, neg_next;
    logic               zp_reg, zp_next;
    logic               upper_reg, upper_next;
    logic [6:0]         width_reg, width_next;
    logic [6:0]         pos_reg, pos_next;
    logic [6:0]         total_reg, total_next;
    logic [6:0]         pad_reg, pad_next;
    logic [6:0]         lead_reg, lead_next;
    logic               valid_reg, valid_next;
    logic [7:0]         char_reg, char_next;
    logic               last_reg, last_next;

    logic [BCD_W-1:0]   dd_a, dd_b, dd_c;
    logic [3:0]         cur_digit;
    logic [6:0]         text_len;

    // Shared double-dabble unit: adjust, shift, adjust, shift.
    always_comb
    begin
        dd_a = bcd_reg;
        for (int i = 0; i < DIGIT_SLOTS; i++)
        begin
            if (dd_a[i*4 +: 4] >= 4'd5)
            begin
                dd_a[i*4 +: 4] = dd_a[i*4 +: 4] + 4'd3;
            end
        end
        dd_b = {dd_a[BCD_W-2:0], mag_reg[VALUE_W-1]};
        for (int i = 0; i < DIGIT_SLOTS; i++)
        begin
            if (dd_b[i*4 +: 4] >= 4'd5)
            begin
                dd_b[i*4 +: 4] = dd_b[i*4 +: 4] + 4'd3;
            end
        end
        dd_c = {dd_b[BCD_W-2:0], mag_reg[VALUE_W-2]};
    end

    assign cur_digit = bcd_reg[idx_reg*4 +: 4];
    assign text_len  = 7'(idx_reg) + 7'd1 + {6'd0, neg_reg};

    always_comb
    begin
        state_next = state_reg;
        mag_next   = mag_reg;
        bcd_next   = bcd_reg;
        step_next  = step_reg;
        idx_next   = idx_reg;
        neg_next   = neg_reg;
        zp_next    = zp_reg;
        upper_next = upper_reg;
        width_next = width_reg;
        pos_next   = pos_reg;
        total_next = total_reg;
        pad_next   = pad_reg;
        lead_next  = lead_reg;
        valid_next = 1'b0;
        char_next  = char_reg;
        last_next  = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    neg_next   = (radix_mode == RADIX_DEC) && value[VALUE_W-1];
                    zp_next    = zero_pad;
                    upper_next = (radix_mode == RADIX_HEX_UPPER);
                    width_next = (field_width > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : field_width;
                    idx_next   = IDX_W'(DIGIT_SLOTS - 1);
                    step_next  = '0;
                    if (radix_mode == RADIX_DEC)
                    begin
                        mag_next   = value[VALUE_W-1] ? (~value + 1'b1) : value;
                        bcd_next   = '0;
                        state_next = ST_CONV;
                    end
                    else
                    begin
                        // hex digits are the value's nibbles as they stand, zero-extended
                        bcd_next   = BCD_W'($unsigned(value));
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_CONV:
            begin
                bcd_next  = dd_c;
                mag_next  = {mag_reg[VALUE_W-3:0], 2'b00};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(STEPS - 1))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // drop leading zero digits, keep at least one
                if (cur_digit != 4'd0 || idx_reg == '0)
                begin
                    total_next = (width_reg > text_len) ? width_reg : text_len;
                    pad_next   = ((width_reg > text_len) ? width_reg : text_len) - text_len;
                    lead_next  = ((width_reg > text_len) ? width_reg : text_len) - text_len
                                 + {6'd0, neg_reg};
                    pos_next   = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    idx_next = idx_reg - 1'b1;
                end
            end
            ST_EMIT:
            begin
                valid_next = 1'b1;
                last_next  = (pos_reg == total_reg - 7'd1);
                if (pos_reg >= lead_reg)
                begin
                    char_next = digit_char(cur_digit, upper_reg);
                    if (idx_reg != '0)
                    begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
                else if (zp_reg)
                begin
                    char_next = (neg_reg && pos_reg == 7'd0) ? CHAR_MINUS : CHAR_ZERO;
                end
                else
                begin
                    char_next = (neg_reg && pos_reg == pad_reg) ? CHAR_MINUS : CHAR_SPACE;
                end
                pos_next = pos_reg + 7'd1;
                if (pos_reg == total_reg - 7'd1)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
            step_reg  <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            step_reg  <= step_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg   <= mag_next;
        bcd_reg   <= bcd_next;
        idx_reg   <= idx_next;
        neg_reg   <= neg_next;
        zp_reg    <= zp_next;
        upper_reg <= upper_next;
        width_reg <= width_next;
        total_reg <= total_next;
        pad_reg   <= pad_next;
        lead_reg  <= lead_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign valid     = valid_reg;
    assign out_char  = char_reg;
    assign last_char = last_reg;

endmodule
